@@ rtl/core/hsvc_pkg.sv @@
// Shared types and constants for the HSV to RGB converter.
// No dependencies; imported by the converter top level and its multiplier.
`timescale 1ns / 1ps

package hsvc_pkg;

   // Width of the color inputs on the ports (unsigned Q0.16).
   localparam int unsigned IN_BITS = 16;

   // Width of one output color channel.
   localparam int unsigned BYTE_BITS = 8;

   // Hue is scaled by six to find the sector of the color wheel.
   localparam logic [2:0] HUE_SECTORS = 3'd6;

   // Full-scale channel value: a channel is this times its fraction.
   localparam logic [BYTE_BITS-1:0] BYTE_MAX = 8'hFF;

   // Sector of the hue wheel, from red toward magenta.
   typedef enum logic [2:0] {
      SECTOR_RED     = 3'd0,
      SECTOR_YELLOW  = 3'd1,
      SECTOR_GREEN   = 3'd2,
      SECTOR_CYAN    = 3'd3,
      SECTOR_BLUE    = 3'd4,
      SECTOR_MAGENTA = 3'd5
   } sector_type;

endpackage

@@ rtl/core/hsvc_frac_mul.sv @@
// Fractional multiplier: (a * b) >> FRAC_BITS for a Q0.F factor and a factor up to one.
// Uses hsvc_pkg only for the common house style; no submodules.
`timescale 1ns / 1ps

module hsvc_frac_mul
   import hsvc_pkg::*;
#(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic [FRAC_BITS-1:0] frac_a,
   input  logic [FRAC_BITS:0]   frac_b,
   output logic [FRAC_BITS-1:0] product
);

   logic [2*FRAC_BITS:0] full_product;

   // The first factor is below one and the second at most one, so the top
   // bit of the full product is always clear and the result fits in Q0.F.
   assign full_product = {{(FRAC_BITS+1){1'b0}}, frac_a} * {{FRAC_BITS{1'b0}}, frac_b};
   assign product      = full_product[2*FRAC_BITS-1:FRAC_BITS];

endmodule

@@ rtl/core/hsv_to_rgb_converter.sv @@
// HSV to 8-bit RGB color converter, four-stage pipeline.
// Depends on hsvc_pkg and hsvc_frac_mul.
`timescale 1ns / 1ps

// Usage:
//   Drive req_hue, req_saturation and req_brightness (unsigned Q0.16) with
//   start high; the transfer is taken at the rising edge where start is high
//   and busy is low. busy stays low, so a new pixel may enter every cycle.
//   The result appears on rsp_red, rsp_green and rsp_blue with rsp_valid high
//   for exactly one cycle, once the pixel has passed every pipeline stage,
//   and is taken at the edge that ends that cycle. Throughput is one pixel per clock.
//   The pipeline stages are the input scaling stage, the two dependent
//   multiplies (s*f, then v*(1-s*f)) and the final channel select and byte
//   scaling stage.
//   Synchronous reset clears the valid bits of every stage, so pixels in
//   flight are dropped and no strobe follows reset.
//   The receiver cannot stall the block: results are never held off.
//   FRAC_BITS sets the internal precision (8 to 24 bits).
module hsv_to_rgb_converter
   import hsvc_pkg::*;
#(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [IN_BITS-1:0]   req_hue,
   input  logic [IN_BITS-1:0]   req_saturation,
   input  logic [IN_BITS-1:0]   req_brightness,
   output logic                 rsp_valid,
   output logic [BYTE_BITS-1:0] rsp_red,
   output logic [BYTE_BITS-1:0] rsp_green,
   output logic [BYTE_BITS-1:0] rsp_blue
);

   localparam int unsigned F = FRAC_BITS;
   localparam logic [F:0]  ONE_FX = {1'b1, {F{1'b0}}};

   // The pipeline never stalls, so a transfer is possible every cycle.
   assign busy = 1'b0;

   // ---------------------------------------------------------------
   // Stage 1: bring inputs to Q0.F, split 6*h into sector and fraction.
   // ---------------------------------------------------------------
   logic [F+IN_BITS-1:0] hue_ext, sat_ext, val_ext;
   logic [F-1:0]         hue_fx, sat_fx, val_fx;
   logic [F+2:0]         hue_six;

   assign hue_ext = {req_hue,        {F{1'b0}}};
   assign sat_ext = {req_saturation, {F{1'b0}}};
   assign val_ext = {req_brightness, {F{1'b0}}};
   assign hue_fx  = hue_ext[F+IN_BITS-1:IN_BITS];
   assign sat_fx  = sat_ext[F+IN_BITS-1:IN_BITS];
   assign val_fx  = val_ext[F+IN_BITS-1:IN_BITS];
   assign hue_six = {3'b000, hue_fx} * {{F{1'b0}}, HUE_SECTORS};

   logic             s1_valid_ff, s1_valid_in;
   logic [2:0]       s1_sector_ff;
   logic [F-1:0]     s1_frac_ff, s1_sat_ff, s1_val_ff;
   logic             s1_grey_ff;

   assign s1_valid_in = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_sector_ff <= hue_six[F+2:F];
      s1_frac_ff   <= hue_six[F-1:0];
      s1_sat_ff    <= sat_fx;
      s1_val_ff    <= val_fx;
      s1_grey_ff   <= (sat_fx == '0);
   end

   // ---------------------------------------------------------------
   // Stage 2: s*f, s*(1-f) and p = v*(1-s).
   // ---------------------------------------------------------------
   logic [F:0]   one_minus_frac, one_minus_sat;
   logic [F-1:0] sat_frac, sat_cofrac, p_value;

   assign one_minus_frac = ONE_FX - {1'b0, s1_frac_ff};
   assign one_minus_sat  = ONE_FX - {1'b0, s1_sat_ff};

   hsvc_frac_mul #(.FRAC_BITS(F)) u_mul_sf (
      .frac_a (s1_sat_ff),
      .frac_b ({1'b0, s1_frac_ff}),
      .product(sat_frac)
   );

   hsvc_frac_mul #(.FRAC_BITS(F)) u_mul_scf (
      .frac_a (s1_sat_ff),
      .frac_b (one_minus_frac),
      .product(sat_cofrac)
   );

   hsvc_frac_mul #(.FRAC_BITS(F)) u_mul_p (
      .frac_a (s1_val_ff),
      .frac_b (one_minus_sat),
      .product(p_value)
   );

   logic         s2_valid_ff;
   logic [2:0]   s2_sector_ff;
   logic [F-1:0] s2_val_ff, s2_sf_ff, s2_scf_ff, s2_p_ff;
   logic         s2_grey_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_sector_ff <= s1_sector_ff;
      s2_val_ff    <= s1_val_ff;
      s2_sf_ff     <= sat_frac;
      s2_scf_ff    <= sat_cofrac;
      s2_p_ff      <= p_value;
      s2_grey_ff   <= s1_grey_ff;
   end

   // ---------------------------------------------------------------
   // Stage 3: q = v*(1-s*f) and t = v*(1-s*(1-f)).
   // ---------------------------------------------------------------
   logic [F-1:0] q_value, t_value;

   hsvc_frac_mul #(.FRAC_BITS(F)) u_mul_q (
      .frac_a (s2_val_ff),
      .frac_b (ONE_FX - {1'b0, s2_sf_ff}),
      .product(q_value)
   );

   hsvc_frac_mul #(.FRAC_BITS(F)) u_mul_t (
      .frac_a (s2_val_ff),
      .frac_b (ONE_FX - {1'b0, s2_scf_ff}),
      .product(t_value)
   );

   logic         s3_valid_ff;
   logic [2:0]   s3_sector_ff;
   logic [F-1:0] s3_val_ff, s3_p_ff, s3_q_ff, s3_t_ff;
   logic         s3_grey_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_sector_ff <= s2_sector_ff;
      s3_val_ff    <= s2_val_ff;
      s3_p_ff      <= s2_p_ff;
      s3_q_ff      <= q_value;
      s3_t_ff      <= t_value;
      s3_grey_ff   <= s2_grey_ff;
   end

   // ---------------------------------------------------------------
   // Stage 4: route by sector (grey pixels take v on every channel), then scale each channel to a byte.
   // ---------------------------------------------------------------
   logic [F-1:0]   red_fx, green_fx, blue_fx;
   logic [F+7:0]   red_full, green_full, blue_full;

   always_comb begin
      red_fx   = s3_val_ff;
      green_fx = s3_val_ff;
      blue_fx  = s3_val_ff;
      if (!s3_grey_ff) begin
         unique case (sector_type'(s3_sector_ff))
            SECTOR_RED: begin
               red_fx = s3_val_ff; green_fx = s3_t_ff;   blue_fx = s3_p_ff;
            end
            SECTOR_YELLOW: begin
               red_fx = s3_q_ff;   green_fx = s3_val_ff; blue_fx = s3_p_ff;
            end
            SECTOR_GREEN: begin
               red_fx = s3_p_ff;   green_fx = s3_val_ff; blue_fx = s3_t_ff;
            end
            SECTOR_CYAN: begin
               red_fx = s3_p_ff;   green_fx = s3_q_ff;   blue_fx = s3_val_ff;
            end
            SECTOR_BLUE: begin
               red_fx = s3_t_ff;   green_fx = s3_p_ff;   blue_fx = s3_val_ff;
            end
            default: begin
               red_fx = s3_val_ff; green_fx = s3_p_ff;   blue_fx = s3_q_ff;
            end
         endcase
      end
   end

   // 255 * x is a constant multiply that synthesis reduces to x*256 - x.
   assign red_full   = {8'd0, red_fx}   * {{F{1'b0}}, BYTE_MAX};
   assign green_full = {8'd0, green_fx} * {{F{1'b0}}, BYTE_MAX};
   assign blue_full  = {8'd0, blue_fx}  * {{F{1'b0}}, BYTE_MAX};

   logic                 s4_valid_ff;
   logic [BYTE_BITS-1:0] s4_red_ff, s4_green_ff, s4_blue_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      s4_red_ff   <= red_full[F+7:F];
      s4_green_ff <= green_full[F+7:F];
      s4_blue_ff  <= blue_full[F+7:F];
   end

   // Result transfer: one strobe per pixel.
   assign rsp_valid = s4_valid_ff;
   assign rsp_red   = s4_red_ff;
   assign rsp_green = s4_green_ff;
   assign rsp_blue  = s4_blue_ff;

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the HSV to RGB converter (hsv_to_rgb_converter).
// Depends on hsvc_pkg and the converter RTL; a scoreboard class predicts each color.
`timescale 1ns / 1ps

import hsvc_pkg::*;

typedef struct packed {
   logic [BYTE_BITS-1:0] red;
   logic [BYTE_BITS-1:0] green;
   logic [BYTE_BITS-1:0] blue;
} rgb_color_type;

// Predicts the color of each accepted pixel and checks the colors that come back.
class rgb_checker;
   localparam int unsigned FRAC = 16;

   rgb_color_type expected_colors[$];
   int unsigned pixels_in;
   int unsigned colors_checked;
   int unsigned mismatches;
   int unsigned grey_pixels;
   int unsigned sector_hits[6];

   // Scales a Q0.FRAC fraction to a channel byte, truncating.
   function automatic logic [BYTE_BITS-1:0] frac_to_byte(input logic [63:0] x);
      logic [63:0] scaled;
      scaled = (64'(BYTE_MAX) * x) >> FRAC;
      return scaled[BYTE_BITS-1:0];
   endfunction

   // Works out the RGB color of one HSV pixel at the converter's precision.
   function automatic rgb_color_type hsv_to_rgb(input logic [IN_BITS-1:0] hue,
                                                input logic [IN_BITS-1:0] sat,
                                                input logic [IN_BITS-1:0] bright);
      logic [63:0]   one, h6, f, v, s, p, q, t, r, g, b;
      sector_type    sector;
      rgb_color_type color;
      one = 64'd1 << FRAC;
      v   = 64'(bright);
      s   = 64'(sat);
      if (s == 0) begin
         r = v;
         g = v;
         b = v;
      end else begin
         h6     = 64'(HUE_SECTORS) * 64'(hue);
         sector = sector_type'(h6[FRAC+2:FRAC]);
         f      = h6 & (one - 1);
         p      = (v * (one - s)) >> FRAC;
         q      = (v * (one - ((s * f) >> FRAC))) >> FRAC;
         t      = (v * (one - ((s * (one - f)) >> FRAC))) >> FRAC;
         sector_hits[h6[FRAC+2:FRAC]]++;
         case (sector)
            SECTOR_RED: begin
               r = v; g = t; b = p;
            end
            SECTOR_YELLOW: begin
               r = q; g = v; b = p;
            end
            SECTOR_GREEN: begin
               r = p; g = v; b = t;
            end
            SECTOR_CYAN: begin
               r = p; g = q; b = v;
            end
            SECTOR_BLUE: begin
               r = t; g = p; b = v;
            end
            default: begin
               r = v; g = p; b = q;
            end
         endcase
      end
      color.red   = frac_to_byte(r);
      color.green = frac_to_byte(g);
      color.blue  = frac_to_byte(b);
      return color;
   endfunction

   // Records a pixel taken by the converter and queues its expected color.
   function void note_pixel(input logic [IN_BITS-1:0] hue,
                            input logic [IN_BITS-1:0] sat,
                            input logic [IN_BITS-1:0] bright);
      pixels_in++;
      if (sat == 0) grey_pixels++;
      expected_colors.push_back(hsv_to_rgb(hue, sat, bright));
   endfunction

   // Compares one returned color with the oldest expected color.
   function void check_color(input logic [BYTE_BITS-1:0] red,
                             input logic [BYTE_BITS-1:0] green,
                             input logic [BYTE_BITS-1:0] blue);
      rgb_color_type want;
      colors_checked++;
      if (expected_colors.size() == 0) begin
         mismatches++;
         $display("%0t: color %0d/%0d/%0d arrived with no pixel outstanding",
                  $time, red, green, blue);
         return;
      end
      want = expected_colors.pop_front();
      if (want.red !== red || want.green !== green || want.blue !== blue) begin
         mismatches++;
         $display("%0t: color mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                  $time, want.red, want.green, want.blue, red, green, blue);
      end
   endfunction

   function int unsigned outstanding();
      return expected_colors.size();
   endfunction
endclass

module testbench;

   localparam int unsigned RANDOM_PIXELS = 1000;
   localparam int unsigned MAX_GAP       = 12;
   localparam int unsigned DRAIN_CYCLES  = 16;

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 start          = 1'b0;
   logic [IN_BITS-1:0]   req_hue        = '0;
   logic [IN_BITS-1:0]   req_saturation = '0;
   logic [IN_BITS-1:0]   req_brightness = '0;
   logic                 busy;
   logic                 rsp_valid;
   logic [BYTE_BITS-1:0] rsp_red;
   logic [BYTE_BITS-1:0] rsp_green;
   logic [BYTE_BITS-1:0] rsp_blue;

   rgb_checker colors = new();
   int unsigned directed_count;

   hsv_to_rgb_converter i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

   // Free-running clock, 8 ns period.
   initial begin
      forever #4 clock = ~clock;
   end

   // Results cannot be held off, so every strobe is a transfer.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         colors.check_color(rsp_red, rsp_green, rsp_blue);
      end
   end

   // Sends one pixel, after an idle gap if one is given, and notes it once the transfer is taken.
   task automatic send_pixel(input logic [IN_BITS-1:0] hue,
                             input logic [IN_BITS-1:0] sat,
                             input logic [IN_BITS-1:0] bright,
                             input int unsigned gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_hue        <= hue;
      req_saturation <= sat;
      req_brightness <= bright;
      do @(posedge clock); while (busy);
      colors.note_pixel(hue, sat, bright);
   endtask

   // Holds the input idle until every outstanding color has come back.
   task automatic drain_colors();
      start <= 1'b0;
      while (colors.outstanding() != 0) @(posedge clock);
   endtask

   // Field value biased toward the extremes, otherwise uniform.
   function automatic logic [IN_BITS-1:0] pick_field();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return IN_BITS'($urandom_range(1, 15));
         3:       return ~IN_BITS'($urandom_range(1, 15));
         default: return IN_BITS'($urandom);
      endcase
   endfunction

   // Sector boundaries of the hue wheel, each side of every edge.
   logic [IN_BITS-1:0] hue_edges[12] = '{
      16'd0, 16'd10922, 16'd10923, 16'd21845, 16'd21846, 16'd32767,
      16'd32768, 16'd43690, 16'd43691, 16'd54613, 16'd54614, 16'hFFFF
   };

   initial begin
      bit          no_gaps;
      int unsigned gap;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed pixels: sector edges at full saturation and value, then grey
      // and the extremes of every field.
      foreach (hue_edges[i]) begin
         send_pixel(hue_edges[i], 16'hFFFF, 16'hFFFF, 0);
      end
      send_pixel(16'h1234, 16'd0,    16'hFFFF, 0);
      send_pixel(16'hBEEF, 16'd0,    16'h8000, 2);
      send_pixel(16'h4000, 16'd0,    16'd0,    0);
      send_pixel(16'h0000, 16'd0,    16'd0,    1);
      send_pixel(16'hFFFF, 16'hFFFF, 16'd0,    0);
      send_pixel(16'h2AAA, 16'd1,    16'hFFFF, 0);
      send_pixel(16'h7FFF, 16'h8000, 16'h8000, 3);
      send_pixel(16'hD555, 16'hFFFF, 16'd1,    0);
      send_pixel(16'h5555, 16'h0001, 16'h0001, 0);
      directed_count = colors.pixels_in;
      drain_colors();

      // Random pixels in bursts; some bursts run back to back, others idle.
      no_gaps = 1'b0;
      for (int unsigned n = 0; n < RANDOM_PIXELS; n++) begin
         if (n % 50 == 0) no_gaps = ($urandom_range(0, 2) == 0);
         if (n == RANDOM_PIXELS / 2) drain_colors();
         gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
         send_pixel(pick_field(), pick_field(), pick_field(), gap);
      end
      start <= 1'b0;

      while (colors.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d pixels (%0d directed, %0d grey); checked %0d colors, %0d bad.",
               colors.pixels_in, directed_count, colors.grey_pixels,
               colors.colors_checked, colors.mismatches);
      $display("Saturated pixels per hue sector: %0d %0d %0d %0d %0d %0d",
               colors.sector_hits[0], colors.sector_hits[1], colors.sector_hits[2],
               colors.sector_hits[3], colors.sector_hits[4], colors.sector_hits[5]);
      if (colors.mismatches == 0 && colors.outstanding() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("Timeout with %0d colors outstanding.", colors.outstanding());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
